@@ rtl/core/emr_pkg.sv @@
// Package for the Eller maze row generator.
// Holds label width, default column count, word types, sequencer states
// and the control bundle that the sequencer drives into the label cells.
package emr_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int LABEL_W     = 6;

  // input word: one maze row request
  typedef struct packed {
    logic        start_maze;
    logic        last_row;
    logic [30:0] right_chance;
    logic [31:0] down_chance;
  } in_word_t;

  // result word: wall vectors of one row
  typedef struct packed {
    logic [31:0] right_walls;
    logic [31:0] bottom_walls;
  } out_word_t;

  // sequencer states: merge sweep, opening fix sweep, fresh label sweep
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FIX,
    ST_FRESH,
    ST_DONE
  } state_t;

  // control bundle broadcast to every cell
  typedef struct packed {
    logic               load;
    logic               start;
    logic               shift;
    logic               relabel;
    logic [LABEL_W-1:0] drop;
    logic [LABEL_W-1:0] keep;
    logic [LABEL_W-1:0] probe;
  } cell_ctl_t;

endpackage

@@ rtl/core/emr_stream_if.sv @@
// Valid/ready stream interface carrying one word per handshake.
// The word type is a parameter; types come from emr_pkg.
interface emr_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/emr_cell.sv @@
// One column cell of the label ring: group label and bottom wall bit.
// Uses emr_pkg for the label width and the control bundle.
module emr_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  emr_pkg::cell_ctl_t         ctl,
  input  logic                       init_bot,
  input  logic [emr_pkg::LABEL_W-1:0] nb_label,
  input  logic                       nb_bot,
  output logic [emr_pkg::LABEL_W-1:0] label,
  output logic                       bot,
  output logic                       open_hit
);

  logic [emr_pkg::LABEL_W-1:0] label_r;
  logic [emr_pkg::LABEL_W-1:0] label_nxt;
  logic                        bot_r;

  // take the neighbor's label, relabeling a dropped group on the way
  always_comb begin
    label_nxt = label_r;
    if (ctl.load) begin
      if (ctl.start) begin
        label_nxt = emr_pkg::LABEL_W'(INDEX);
      end
    end else if (ctl.shift) begin
      if (ctl.relabel && (nb_label == ctl.drop)) begin
        label_nxt = ctl.keep;
      end else begin
        label_nxt = nb_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= emr_pkg::LABEL_W'(INDEX);
    end else begin
      label_r <= label_nxt;
    end
  end

  // bottom bit travels with the label
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bot_r <= init_bot;
    end else if (ctl.shift) begin
      bot_r <= nb_bot;
    end
  end

  // flag an open-bottom member of the probed group
  assign open_hit = (label_r == ctl.probe) && !bot_r;
  assign label    = label_r;
  assign bot      = bot_r;

endmodule

@@ rtl/core/emr_seq.sv @@
// Row sequencer: state machine, step counter, wall and used-label vectors,
// fresh label search and the output register. Uses emr_pkg types and states.
module emr_seq #(
  parameter int COLUMNS = emr_pkg::COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_start,
  input  logic                        in_last,
  input  logic [30:0]                 in_rchance,
  input  logic [emr_pkg::LABEL_W-1:0] head_label,
  input  logic                        head_bot,
  input  logic [emr_pkg::LABEL_W-1:0] next_label,
  input  logic                        open_any,
  input  logic [COLUMNS-1:0]          bot_vec,
  output emr_pkg::cell_ctl_t          ctl,
  output logic [emr_pkg::LABEL_W-1:0] feed_label,
  output logic                        feed_bot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output emr_pkg::out_word_t          out_data
);

  localparam int IDX_W = $clog2(COLUMNS);

  emr_pkg::state_t    state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic               last_r;
  logic [COLUMNS-2:0] rc_r;
  logic [COLUMNS-1:0] right_r;
  logic [COLUMNS-1:0] used_r, used_nxt;
  logic               out_valid_r;
  emr_pkg::out_word_t out_data_r;

  logic               cnt_last;
  logic               wall;
  logic               sweeping;
  logic               emit;
  logic [IDX_W-1:0]   fresh_idx;
  logic [IDX_W-1:0]   head_idx;

  // lowest label not yet in use
  function automatic logic [IDX_W-1:0] first_free(input logic [COLUMNS-1:0] used);
    logic [IDX_W-1:0] res;
    res = '0;
    for (int k = COLUMNS - 1; k >= 0; k--) begin
      if (!used[k]) begin
        res = IDX_W'(k);
      end
    end
    return res;
  endfunction

  assign cnt_last  = (cnt_r == IDX_W'(COLUMNS - 1));
  assign head_idx  = head_label[IDX_W-1:0];
  assign fresh_idx = first_free(used_r);
  assign wall      = (head_label == next_label) || (!last_r && rc_r[0]) || cnt_last;
  assign sweeping  = (state_r == emr_pkg::ST_MERGE) || (state_r == emr_pkg::ST_FIX) ||
                     (state_r == emr_pkg::ST_FRESH);
  assign emit      = (state_r == emr_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = emr_pkg::ST_MERGE;
        end
      end
      emr_pkg::ST_MERGE: begin
        if (cnt_last) begin
          state_nxt = last_r ? emr_pkg::ST_DONE : emr_pkg::ST_FIX;
        end
      end
      emr_pkg::ST_FIX: begin
        if (cnt_last) begin
          state_nxt = emr_pkg::ST_FRESH;
        end
      end
      emr_pkg::ST_FRESH: begin
        if (cnt_last) begin
          state_nxt = emr_pkg::ST_DONE;
        end
      end
      emr_pkg::ST_DONE: begin
        if (emit) begin
          state_nxt = emr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = emr_pkg::ST_IDLE;
    endcase
  end

  // cell controls and the value fed back into the ring tail
  always_comb begin
    in_ready    = (state_r == emr_pkg::ST_IDLE);
    ctl.load    = (state_r == emr_pkg::ST_IDLE) && in_valid;
    ctl.start   = in_start;
    ctl.shift   = sweeping;
    ctl.relabel = 1'b0;
    ctl.drop    = next_label;
    ctl.keep    = head_label;
    ctl.probe   = head_label;
    feed_label  = head_label;
    feed_bot    = head_bot;
    case (state_r)
      emr_pkg::ST_MERGE: begin
        ctl.relabel = !wall;
      end
      emr_pkg::ST_FIX: begin
        feed_bot = head_bot && open_any;
      end
      emr_pkg::ST_FRESH: begin
        if (head_bot) begin
          feed_label = emr_pkg::LABEL_W'(fresh_idx);
        end
      end
      default: begin
      end
    endcase
  end

  // collect labels held by open cells and by fresh assignments
  always_comb begin
    used_nxt = used_r;
    if (ctl.load) begin
      used_nxt = '0;
    end else if ((state_r == emr_pkg::ST_FIX) && !feed_bot) begin
      used_nxt = used_r | (COLUMNS'(1) << head_idx);
    end else if ((state_r == emr_pkg::ST_FRESH) && head_bot) begin
      used_nxt = used_r | (COLUMNS'(1) << fresh_idx);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load || (sweeping && cnt_last)) begin
        cnt_r <= '0;
      end else if (sweeping) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // row data registers
  always_ff @(posedge clk) begin
    used_r <= used_nxt;
    if (ctl.load) begin
      last_r  <= in_last;
      rc_r    <= in_rchance[COLUMNS-2:0];
      right_r <= '0;
    end else if (state_r == emr_pkg::ST_MERGE) begin
      rc_r    <= rc_r >> 1;
      right_r <= {wall, right_r[COLUMNS-1:1]};
    end
    if (emit) begin
      out_data_r.right_walls  <= 32'(right_r);
      out_data_r.bottom_walls <= 32'(bot_vec);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/core/eller_maze_row_generator.sv @@
// Eller maze row generator, one row per input word.
// Each accepted word runs three sweeps of the label ring, one column per cycle:
// merge, bottom opening fix, fresh labels; a last row runs only the merge sweep.
// No new word is taken until the row's result has moved into the output register.
// Reset: rst_n low sets each column label to its index and empties the output.
// A new word is taken while a finished result still waits in the output register.
module eller_maze_row_generator #(
  parameter int COLUMNS = emr_pkg::COLUMNS_DEF
) (
  input logic clk,
  input logic rst_n,
  emr_stream_if.sink   in_chan,
  emr_stream_if.source out_chan
);

  emr_pkg::cell_ctl_t          ctl;
  logic [emr_pkg::LABEL_W-1:0] labels [COLUMNS];
  logic [COLUMNS-1:0]          bots;
  logic [COLUMNS-1:0]          hits;
  logic [emr_pkg::LABEL_W-1:0] feed_label;
  logic                        feed_bot;
  emr_pkg::in_word_t           in_word;
  emr_pkg::out_word_t          out_word;

  assign in_word       = in_chan.data;
  assign out_chan.data = out_word;

  // ring of column cells, head at column zero
  for (genvar j = 0; j < COLUMNS; j++) begin : g_cell
    logic [emr_pkg::LABEL_W-1:0] nb_label;
    logic                        nb_bot;
    if (j == COLUMNS - 1) begin : g_tail
      assign nb_label = feed_label;
      assign nb_bot   = feed_bot;
    end else begin : g_mid
      assign nb_label = labels[j+1];
      assign nb_bot   = bots[j+1];
    end
    emr_cell #(
      .INDEX(j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .init_bot(in_word.down_chance[j] | in_word.last_row),
      .nb_label(nb_label),
      .nb_bot  (nb_bot),
      .label   (labels[j]),
      .bot     (bots[j]),
      .open_hit(hits[j])
    );
  end

  emr_seq #(
    .COLUMNS(COLUMNS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_start  (in_word.start_maze),
    .in_last   (in_word.last_row),
    .in_rchance(in_word.right_chance),
    .head_label(labels[0]),
    .head_bot  (bots[0]),
    .next_label(labels[1]),
    .open_any  (|hits),
    .bot_vec   (bots),
    .ctl       (ctl),
    .feed_label(feed_label),
    .feed_bot  (feed_bot),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_word)
  );

endmodule

@@ rtl/core/emr_checker.sv @@
// Port-level checks for the Eller maze row generator, bound to the top level.
// Uses emr_pkg for the word types.
module emr_checker #(
  parameter int COLUMNS = emr_pkg::COLUMNS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input emr_pkg::out_word_t out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one row in flight: no second accept right after one
  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a row is in progress");

  // outer edge wall is always present, unused columns are clear
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.right_walls[COLUMNS-1] &&
                  ((out_data.right_walls >> COLUMNS) == 32'd0))
    else $error("right wall vector malformed");

  a_bottom_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.bottom_walls >> COLUMNS) == 32'd0))
    else $error("bottom wall beyond last column");

endmodule

bind eller_maze_row_generator emr_checker #(
  .COLUMNS(COLUMNS)
) u_emr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_chan.valid),
  .in_ready (in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_data (out_chan.data)
);
